>>> hw/rtl/fpidw_pkg.sv
`default_nettype none
package fpidw_pkg;

  localparam int CHANNEL_BITS_DEF = 8;

  localparam int CW       = 24;  // coordinate width
  localparam int AW       = 24;  // magnitude of a coordinate difference
  localparam int SQW      = 49;  // squared distance
  localparam int DW       = 25;  // distance after square root
  localparam int PW       = 2 * DW;
  localparam int WW       = 3 * DW;
  localparam int DENW     = WW + 2;
  localparam int COLW     = 16;
  localparam int PPW      = DW + COLW;
  localparam int PRODW    = WW + COLW;
  localparam int NUMW     = PRODW + 2;
  localparam int QW       = 17;
  localparam int SQRT_STEPS = DW;
  localparam int DIV_STEPS  = QW;

  localparam logic [47:0] PT1_RST  = 48'd858993510400;
  localparam logic [47:0] PT2_RST  = 48'd280615983302656;
  localparam logic [47:0] PT3_RST  = 48'd280615999977472;
  localparam logic [47:0] PT4_RST  = 48'd859010185216;
  localparam logic [31:0] COL1_RST = 32'd4278190335;
  localparam logic [31:0] COL2_RST = 32'd16711935;
  localparam logic [31:0] COL3_RST = 32'd65535;
  localparam logic [31:0] COL4_RST = 32'd4294902015;

  typedef enum logic [2:0] {
    REG_POINT_ONE   = 3'd0,
    REG_POINT_TWO   = 3'd1,
    REG_POINT_THREE = 3'd2,
    REG_POINT_FOUR  = 3'd3,
    REG_COLOR_ONE   = 3'd4,
    REG_COLOR_TWO   = 3'd5,
    REG_COLOR_THREE = 3'd6,
    REG_COLOR_FOUR  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } hit_t;

  // channel k of a packed rgba word, widened by 257 for 16-bit channels
  function automatic logic [COLW-1:0] chan(input logic [31:0] rgba, input logic [1:0] k,
                                           input logic wide);
    logic [7:0] c;
    c = rgba[31 - 8 * k -: 8];
    return wide ? {c, c} : {8'd0, c};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/four_point_idw_gradient.sv
// channel   | ports                                     | handshake
// ----------+-------------------------------------------+---------------------------
// input     | in_pos_x, in_pos_y                        | start, busy (always low)
// result    | out_red, out_green, out_blue, out_alpha   | out_valid, one-cycle strobe
// config    | cfg_index, cfg_data                       | cfg_valid, cfg_ready (high)
//
// one item enters every clock.
// the pipeline runs through the square root (one root bit per stage, 25 stages) and the
// divider (one quotient bit per stage, 17 stages), with multiplier stages between them.
// rst_n clears the valid bits and loads the default points and colours.
// nothing in the pipeline ever stalls: the receiver takes every result.
`default_nettype none
module four_point_idw_gradient #(
  parameter int CHANNEL_BITS = fpidw_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  output logic             out_valid,
  output logic [15:0]      out_red,
  output logic [15:0]      out_green,
  output logic [15:0]      out_blue,
  output logic [15:0]      out_alpha,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  localparam int SQW  = fpidw_pkg::SQW;
  localparam int DW   = fpidw_pkg::DW;
  localparam int PW   = fpidw_pkg::PW;
  localparam int WW   = fpidw_pkg::WW;
  localparam int DENW = fpidw_pkg::DENW;
  localparam int COLW = fpidw_pkg::COLW;
  localparam int PPW  = fpidw_pkg::PPW;
  localparam int PRODW = fpidw_pkg::PRODW;
  localparam int NUMW = fpidw_pkg::NUMW;
  localparam int QW   = fpidw_pkg::QW;
  localparam int NS   = fpidw_pkg::SQRT_STEPS;
  localparam int ND   = fpidw_pkg::DIV_STEPS;
  localparam logic WIDE = (CHANNEL_BITS >= 16);

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic [47:0] pt_r  [4];
  logic [31:0] col_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r[0]  <= fpidw_pkg::PT1_RST;
      pt_r[1]  <= fpidw_pkg::PT2_RST;
      pt_r[2]  <= fpidw_pkg::PT3_RST;
      pt_r[3]  <= fpidw_pkg::PT4_RST;
      col_r[0] <= fpidw_pkg::COL1_RST;
      col_r[1] <= fpidw_pkg::COL2_RST;
      col_r[2] <= fpidw_pkg::COL3_RST;
      col_r[3] <= fpidw_pkg::COL4_RST;
    end else if (cfg_valid) begin
      case (fpidw_pkg::reg_idx_t'(cfg_index))
        fpidw_pkg::REG_POINT_ONE:   pt_r[0]  <= cfg_data;
        fpidw_pkg::REG_POINT_TWO:   pt_r[1]  <= cfg_data;
        fpidw_pkg::REG_POINT_THREE: pt_r[2]  <= cfg_data;
        fpidw_pkg::REG_POINT_FOUR:  pt_r[3]  <= cfg_data;
        fpidw_pkg::REG_COLOR_ONE:   col_r[0] <= cfg_data[31:0];
        fpidw_pkg::REG_COLOR_TWO:   col_r[1] <= cfg_data[31:0];
        fpidw_pkg::REG_COLOR_THREE: col_r[2] <= cfg_data[31:0];
        fpidw_pkg::REG_COLOR_FOUR:  col_r[3] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                   v0_r;
  logic signed [23:0]     px0_r, py0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start;
    px0_r <= in_pos_x;
    py0_r <= in_pos_y;
  end

  // absolute differences
  logic        v1_r;
  logic [23:0] ax1_r [4];
  logic [23:0] ay1_r [4];
  logic [23:0] ax1_nxt [4];
  logic [23:0] ay1_nxt [4];

  always_comb begin
    logic signed [24:0] dx, dy;
    for (int i = 0; i < 4; i++) begin
      dx = 25'(signed'(pt_r[i][47:24])) - 25'(px0_r);
      dy = 25'(signed'(pt_r[i][23:0])) - 25'(py0_r);
      ax1_nxt[i] = dx[24] ? 24'(-dx) : dx[23:0];
      ay1_nxt[i] = dy[24] ? 24'(-dy) : dy[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
    ax1_r <= ax1_nxt;
    ay1_r <= ay1_nxt;
  end

  // squares
  logic        v2_r;
  logic [47:0] ax2_r [4];
  logic [47:0] ay2_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    for (int i = 0; i < 4; i++) begin
      ax2_r[i] <= ax1_r[i] * ax1_r[i];
      ay2_r[i] <= ay1_r[i] * ay1_r[i];
    end
  end

  // squared distance, point-hit detection, then square root one bit per stage
  logic           sv_r [0:NS];
  fpidw_pkg::hit_t sh_r [0:NS];
  logic [SQW-1:0] sn_r [0:NS][4];
  logic [SQW-1:0] sr_r [0:NS][4];

  fpidw_pkg::hit_t hit_nxt;
  logic [SQW-1:0]  sq_nxt [4];

  always_comb begin
    hit_nxt = '0;
    for (int i = 3; i >= 0; i--) begin
      sq_nxt[i] = SQW'(ax2_r[i]) + SQW'(ay2_r[i]);
      if (sq_nxt[i] == '0) begin
        hit_nxt.hit = 1'b1;
        hit_nxt.idx = 2'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else        sv_r[0] <= v2_r;
    sh_r[0] <= hit_nxt;
    for (int i = 0; i < 4; i++) begin
      sn_r[0][i] <= sq_nxt[i];
      sr_r[0][i] <= '0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_sqrt
    localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * (NS - 1 - s));
    logic [SQW-1:0] n_nxt [4];
    logic [SQW-1:0] r_nxt [4];

    always_comb begin
      logic [SQW-1:0] trial;
      for (int i = 0; i < 4; i++) begin
        trial = sr_r[s][i] + BITV;
        if (sn_r[s][i] >= trial) begin
          n_nxt[i] = sn_r[s][i] - trial;
          r_nxt[i] = (sr_r[s][i] >> 1) + BITV;
        end else begin
          n_nxt[i] = sn_r[s][i];
          r_nxt[i] = sr_r[s][i] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[s+1] <= 1'b0;
      else        sv_r[s+1] <= sv_r[s];
      sh_r[s+1] <= sh_r[s];
      for (int i = 0; i < 4; i++) begin
        sn_r[s+1][i] <= n_nxt[i];
        sr_r[s+1][i] <= r_nxt[i];
      end
    end
  end

  // weights: pair products, then split 50x25 products
  logic            m1v_r;
  fpidw_pkg::hit_t m1h_r;
  logic [PW-1:0]   p01_r, p23_r;
  logic [DW-1:0]   d1_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) m1v_r <= 1'b0;
    else        m1v_r <= sv_r[NS];
    m1h_r <= sh_r[NS];
    p01_r <= sr_r[NS][0][DW-1:0] * sr_r[NS][1][DW-1:0];
    p23_r <= sr_r[NS][2][DW-1:0] * sr_r[NS][3][DW-1:0];
    for (int i = 0; i < 4; i++) d1_r[i] <= sr_r[NS][i][DW-1:0];
  end

  logic            m2v_r;
  fpidw_pkg::hit_t m2h_r;
  logic [PW-1:0]   plo_r [4];
  logic [PW-1:0]   phi_r [4];
  logic [PW-1:0]   pp_sel [4];
  logic [DW-1:0]   dd_sel [4];

  always_comb begin
    pp_sel[0] = p23_r; dd_sel[0] = d1_r[1];
    pp_sel[1] = p23_r; dd_sel[1] = d1_r[0];
    pp_sel[2] = p01_r; dd_sel[2] = d1_r[3];
    pp_sel[3] = p01_r; dd_sel[3] = d1_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m2v_r <= 1'b0;
    else        m2v_r <= m1v_r;
    m2h_r <= m1h_r;
    for (int i = 0; i < 4; i++) begin
      plo_r[i] <= pp_sel[i][DW-1:0] * dd_sel[i];
      phi_r[i] <= pp_sel[i][PW-1:DW] * dd_sel[i];
    end
  end

  logic            m3v_r;
  fpidw_pkg::hit_t m3h_r;
  logic [WW-1:0]   w_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) m3v_r <= 1'b0;
    else        m3v_r <= m2v_r;
    m3h_r <= m2h_r;
    for (int i = 0; i < 4; i++) w_r[i] <= WW'(plo_r[i]) + (WW'(phi_r[i]) << DW);
  end

  // denominator, and weight times colour in three slices
  logic            m4v_r;
  fpidw_pkg::hit_t m4h_r;
  logic [DENW-1:0] den4_r;
  logic [PPW-1:0]  pp_r [4][4][3];

  always_ff @(posedge clk) begin
    logic [COLW-1:0] c;
    if (!rst_n) m4v_r <= 1'b0;
    else        m4v_r <= m3v_r;
    m4h_r  <= m3h_r;
    den4_r <= (DENW'(w_r[0]) + DENW'(w_r[1])) + (DENW'(w_r[2]) + DENW'(w_r[3]));
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        c = fpidw_pkg::chan(col_r[i], 2'(k), WIDE);
        pp_r[i][k][0] <= w_r[i][DW-1:0] * c;
        pp_r[i][k][1] <= w_r[i][2*DW-1:DW] * c;
        pp_r[i][k][2] <= w_r[i][WW-1:2*DW] * c;
      end
    end
  end

  logic            m5v_r;
  fpidw_pkg::hit_t m5h_r;
  logic [DENW-1:0] den5_r;
  logic [PRODW-1:0] prod_r [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) m5v_r <= 1'b0;
    else        m5v_r <= m4v_r;
    m5h_r  <= m4h_r;
    den5_r <= den4_r;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[i][k] <= PRODW'(pp_r[i][k][0]) + (PRODW'(pp_r[i][k][1]) << DW)
                        + (PRODW'(pp_r[i][k][2]) << (2 * DW));
      end
    end
  end

  // numerators feed the divider, one quotient bit per stage
  logic            dv_r [0:ND];
  fpidw_pkg::hit_t dh_r [0:ND];
  logic [DENW-1:0] dd_r [0:ND];
  logic [NUMW-1:0] dn_r [0:ND][4];
  logic [QW-1:0]   dq_r [0:ND][4];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= m5v_r;
    dh_r[0] <= m5h_r;
    dd_r[0] <= den5_r;
    for (int k = 0; k < 4; k++) begin
      dn_r[0][k] <= (NUMW'(prod_r[0][k]) + NUMW'(prod_r[1][k]))
                    + (NUMW'(prod_r[2][k]) + NUMW'(prod_r[3][k]));
      dq_r[0][k] <= '0;
    end
  end

  for (genvar s = 0; s < ND; s++) begin : g_div
    localparam int B = ND - 1 - s;
    logic [NUMW-1:0] n_nxt [4];
    logic [QW-1:0]   q_nxt [4];

    always_comb begin
      logic [NUMW-1:0] t;
      t = NUMW'(dd_r[s]) << B;
      for (int k = 0; k < 4; k++) begin
        if (t <= dn_r[s][k]) begin
          n_nxt[k] = dn_r[s][k] - t;
          q_nxt[k] = dq_r[s][k] | (QW'(1) << B);
        end else begin
          n_nxt[k] = dn_r[s][k];
          q_nxt[k] = dq_r[s][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[s+1] <= 1'b0;
      else        dv_r[s+1] <= dv_r[s];
      dh_r[s+1] <= dh_r[s];
      dd_r[s+1] <= dd_r[s];
      for (int k = 0; k < 4; k++) begin
        dn_r[s+1][k] <= n_nxt[k];
        dq_r[s+1][k] <= q_nxt[k];
      end
    end
  end

  // output register: a pixel on a point takes that point's colour
  logic            out_valid_r;
  logic [15:0]     out_ch_r  [4];
  logic [15:0]     out_ch_nxt [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dh_r[ND].hit) out_ch_nxt[k] = fpidw_pkg::chan(col_r[dh_r[ND].idx], 2'(k), WIDE);
      else              out_ch_nxt[k] = dq_r[ND][k][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_r[ND];
    out_ch_r <= out_ch_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_ch_r[0];
  assign out_green = out_ch_r[1];
  assign out_blue  = out_ch_r[2];
  assign out_alpha = out_ch_r[3];

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int LATENCY = 53;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } pixel_t;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic [15:0] a;
  } colour_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_y = '0;
  logic out_valid;
  logic [15:0] out_red, out_green, out_blue, out_alpha;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  fpidw_pkg::reg_idx_t cfg_index = fpidw_pkg::REG_POINT_ONE;
  logic [47:0] cfg_data = '0;

  four_point_idw_gradient DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_alpha(out_alpha),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [47:0] point_reg [4];
  logic [31:0] colour_reg [4];

  pixel_t pixel_queue[$];
  colour_t colour_queue[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int idle_pct = 18;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int quiet_cycles = 0;

  function automatic logic [15:0] channel_of(logic [31:0] rgba, int k);
    logic [7:0] c;
    c = rgba[31 - 8 * k -: 8];
    return (fpidw_pkg::CHANNEL_BITS_DEF >= 16) ? {c, c} : {8'd0, c};
  endfunction

  function automatic logic [24:0] int_sqrt(logic [48:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int b = 24; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(n)) root = trial;
    end
    return root[24:0];
  endfunction

  function automatic colour_t blend(pixel_t p);
    colour_t res;
    logic signed [25:0] dx, dy;
    logic [48:0] sq;
    logic [24:0] root_d [4];
    logic [127:0] w [4];
    logic [127:0] den, num;
    logic [15:0] ch [4];
    for (int i = 0; i < 4; i++) begin
      dx = $signed(point_reg[i][47:24]) - p.x;
      dy = $signed(point_reg[i][23:0]) - p.y;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq = 49'(dx) * 49'(dx) + 49'(dy) * 49'(dy);
      if (sq == 0) begin
        res.r = channel_of(colour_reg[i], 0);
        res.g = channel_of(colour_reg[i], 1);
        res.b = channel_of(colour_reg[i], 2);
        res.a = channel_of(colour_reg[i], 3);
        return res;
      end
      root_d[i] = int_sqrt(sq);
    end
    w[0] = 128'(root_d[1]) * root_d[2] * root_d[3];
    w[1] = 128'(root_d[0]) * root_d[2] * root_d[3];
    w[2] = 128'(root_d[0]) * root_d[1] * root_d[3];
    w[3] = 128'(root_d[0]) * root_d[1] * root_d[2];
    den = w[0] + w[1] + w[2] + w[3];
    for (int k = 0; k < 4; k++) begin
      num = 0;
      for (int i = 0; i < 4; i++) num += w[i] * channel_of(colour_reg[i], k);
      ch[k] = 16'(num / den);
    end
    res.r = ch[0];
    res.g = ch[1];
    res.b = ch[2];
    res.a = ch[3];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic queue_pixel(logic signed [23:0] x, logic signed [23:0] y);
    pixel_t p;
    p.x = x;
    p.y = y;
    pixel_queue = {pixel_queue, p};
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      colour_queue = {colour_queue, blend({in_pos_x, in_pos_y})};
      sent++;
    end
    if (rst_n && !hold_off && pixel_queue.size() > 0 && (!start || !busy)
        && $urandom_range(99) >= idle_pct) begin
      pixel_t p;
      p = pixel_queue.pop_front();
      start <= 1'b1;
      in_pos_x <= p.x;
      in_pos_y <= p.y;
    end else if (!start || !busy) begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      received++;
      if (colour_queue.size() == 0) begin
        $display("error at %0t: unexpected result", $realtime);
        errors++;
      end else begin
        colour_t e;
        e = colour_queue.pop_front();
        if (out_red !== e.r) report_mismatch("red", out_red, e.r);
        if (out_green !== e.g) report_mismatch("green", out_green, e.g);
        if (out_blue !== e.b) report_mismatch("blue", out_blue, e.b);
        if (out_alpha !== e.a) report_mismatch("alpha", out_alpha, e.a);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready) || stim_done
        || (pixel_queue.size() == 0 && colour_queue.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("four_point_idw_gradient: mismatch");
      $finish;
    end
  end

  task automatic write_reg(fpidw_pkg::reg_idx_t idx, logic [47:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < fpidw_pkg::REG_COLOR_ONE) point_reg[idx] = value;
    else colour_reg[idx - fpidw_pkg::REG_COLOR_ONE] = value[31:0];
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while ((pixel_queue.size() > 0 || start || colour_queue.size() > 0) && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(4))
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(2 * 256 * 256))) - 24'sd65536;
      default: return $signed(24'($urandom_range(1024 * 256))) - 24'sd131072;
    endcase
  endfunction

  task automatic random_pixels(int n);
    int j;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        // land exactly on a configured point
        j = $urandom_range(3);
        queue_pixel(point_reg[j][47:24], point_reg[j][23:0]);
      end else begin
        queue_pixel(rand_coord(), rand_coord());
      end
    end
  endtask

  task automatic random_setting;
    logic [23:0] px, py;
    for (int i = 0; i < 4; i++) begin
      px = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(2 ** 17));
      py = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(2 ** 17));
      write_reg(fpidw_pkg::reg_idx_t'(i), {px, py});
    end
    for (int i = 4; i < 8; i++) write_reg(fpidw_pkg::reg_idx_t'(i), {16'd0, 32'($urandom)});
  endtask

  initial begin
    point_reg[0] = fpidw_pkg::PT1_RST;
    point_reg[1] = fpidw_pkg::PT2_RST;
    point_reg[2] = fpidw_pkg::PT3_RST;
    point_reg[3] = fpidw_pkg::PT4_RST;
    colour_reg[0] = fpidw_pkg::COL1_RST;
    colour_reg[1] = fpidw_pkg::COL2_RST;
    colour_reg[2] = fpidw_pkg::COL3_RST;
    colour_reg[3] = fpidw_pkg::COL4_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed items on the reset points and colours
    queue_pixel(24'sd51200, 24'sd51200);
    queue_pixel(-24'sd51200, 24'sd51200);
    queue_pixel(-24'sd51200, -24'sd51200);
    queue_pixel(24'sd51200, -24'sd51200);
    queue_pixel(24'sd0, 24'sd0);
    queue_pixel(24'sh7fffff, 24'sh7fffff);
    queue_pixel(24'sh800000, 24'sh800000);
    queue_pixel(24'sh7fffff, 24'sh800000);
    queue_pixel(24'sh800000, 24'sh7fffff);
    queue_pixel(24'sd1, -24'sd1);
    queue_pixel(24'sd51201, 24'sd51200);
    queue_pixel(24'sh555555, 24'shaaaaaa);
    queue_pixel(24'shaaaaaa, 24'sh555555);
    drain();

    // coincident points: lower index wins; colour extremes
    write_reg(fpidw_pkg::REG_POINT_ONE, {24'd0, 24'd0});
    write_reg(fpidw_pkg::REG_POINT_TWO, {24'd0, 24'd0});
    write_reg(fpidw_pkg::REG_POINT_THREE, {24'h7fffff, 24'h800000});
    write_reg(fpidw_pkg::REG_POINT_FOUR, {24'h800000, 24'h7fffff});
    write_reg(fpidw_pkg::REG_COLOR_ONE, 48'hffff_ffffffff);
    write_reg(fpidw_pkg::REG_COLOR_TWO, 48'd0);
    write_reg(fpidw_pkg::REG_COLOR_THREE, 48'h0000_80402010);
    write_reg(fpidw_pkg::REG_COLOR_FOUR, 48'h0000_01fe7f80);
    queue_pixel(24'sd0, 24'sd0);
    queue_pixel(24'sh7fffff, 24'sh800000);
    queue_pixel(24'sh800000, 24'sh7fffff);
    queue_pixel(24'sh7fffff, 24'sh7fffff);
    queue_pixel(24'sh800000, 24'sh800000);
    queue_pixel(24'sd3, 24'sd4);
    random_pixels(60);
    drain();

    // points at both extremes of their fields, at -1 and at the origin
    write_reg(fpidw_pkg::REG_POINT_ONE, 48'hffffff_ffffff);
    write_reg(fpidw_pkg::REG_POINT_TWO, 48'h7fffff_7fffff);
    write_reg(fpidw_pkg::REG_POINT_THREE, 48'h800000_800000);
    write_reg(fpidw_pkg::REG_POINT_FOUR, 48'h000000_000000);
    random_pixels(60);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      random_setting();
      idle_pct = (phase == 1) ? 0 : 18;
      random_pixels(100);
      if (phase == 2) begin
        // pause the sender until the pipeline has emptied
        while (pixel_queue.size() > 50) @(posedge clk);
        hold_off = 1'b1;
        while (start || colour_queue.size() > 0) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    stim_done = 1'b1;
    $display("sent %0d pixels, checked %0d colours over several point and colour settings",
             sent, received);
    if (errors == 0) begin
      $display("four_point_idw_gradient: match");
    end else begin
      $display("four_point_idw_gradient: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/fpidw_pkg.sv
hw/rtl/four_point_idw_gradient.sv
tb/testbench.sv
